// File: rtl/u8d_pkg.sv
package u8d_pkg;

  localparam int BYTE_W = 8;
  localparam int CP_W   = 21;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CP_W-1:0]   cp_t;
  typedef logic [1:0]        cnt_t;

  localparam cp_t REPL_CP = 21'h00FFFD;

  localparam logic [2:0] LEAD2_TAG = 3'b110;
  localparam logic [3:0] LEAD3_TAG = 4'b1110;
  localparam logic [4:0] LEAD4_TAG = 5'b11110;

endpackage

// File: rtl/u8d_byte_if.sv
interface u8d_byte_if;
  logic           valid;
  logic           ready;
  u8d_pkg::byte_t in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// File: rtl/u8d_res_if.sv
interface u8d_res_if;
  logic         valid;
  logic         ready;
  u8d_pkg::cp_t code_point;
  logic         is_end;
  logic         last;

  modport source (output valid, output code_point, output is_end, output last, input ready);
  modport sink (input valid, input code_point, input is_end, input last, output ready);
endinterface

// File: rtl/utf8_lenient_decoder.sv
// channel   | dir | word
// ----------+-----+---------------------------------------------
// in_ch     | in  | in_byte[7:0], zero ends the string
// out_ch    | out | code_point[20:0], is_end, last
//
// One byte per cycle while out_ch is not stalled and no flush runs; a nonzero
// byte's code point, if any, is in the result register on the next cycle.
// A zero byte loads its first word at once; with bytes buffered, the flush
// sequencer then replays the buffered bytes one at a time and loads words,
// with in_ch.ready low until the end word is loaded.
// Reset clears the buffer count and the sequencer; a stalled out_ch holds all.
module utf8_lenient_decoder_core (
  input  logic clk,
  input  logic rst_n,
  u8d_byte_if.sink  in_ch,
  u8d_res_if.source out_ch
);

  localparam logic ST_RUN   = 1'b0;
  localparam logic ST_FLUSH = 1'b1;

  logic                st_r, st_nxt;
  u8d_pkg::byte_t      pend_r [3];
  u8d_pkg::byte_t      pend_nxt [3];
  u8d_pkg::cnt_t       cnt_r, cnt_nxt;
  u8d_pkg::byte_t      q_r [2];
  u8d_pkg::byte_t      q_nxt [2];
  u8d_pkg::cnt_t       qn_r, qn_nxt;
  logic                out_valid_r, out_valid_nxt;
  u8d_pkg::cp_t        cp_r, cp_nxt;
  logic                end_r, end_nxt;
  logic                last_r, last_nxt;

  logic                adv, in_ready, in_fire;
  u8d_pkg::byte_t      push_b, lead;
  logic                need2, need3;
  u8d_pkg::cnt_t       need_m1;
  logic                p_emit;
  u8d_pkg::cp_t        p_cp;
  u8d_pkg::byte_t      p_pend [3];
  u8d_pkg::cnt_t       p_cnt;

  assign adv      = !out_valid_r || out_ch.ready;
  assign in_ready = (st_r == ST_RUN) && adv;
  assign in_fire  = in_ch.valid && in_ready;

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.code_point = cp_r;
  assign out_ch.is_end     = end_r;
  assign out_ch.last       = last_r;

  assign push_b = (st_r == ST_FLUSH) ? q_r[0] : in_ch.in_byte;
  assign lead   = pend_r[0];
  assign need2  = (lead[7:5] == u8d_pkg::LEAD2_TAG);
  assign need3  = (lead[7:4] == u8d_pkg::LEAD3_TAG);

  always_comb begin
    if (need2) begin
      need_m1 = 2'd1;
    end else if (need3) begin
      need_m1 = 2'd2;
    end else begin
      need_m1 = 2'd3;
    end
  end

  // push one nonzero byte: buffer it, or emit the code point or replacement it yields
  always_comb begin
    p_emit = 1'b0;
    p_cp   = '0;
    p_pend = pend_r;
    p_cnt  = cnt_r;
    if (cnt_r == 2'd0) begin
      if (!push_b[7]) begin
        p_emit = 1'b1;
        p_cp   = {13'd0, push_b};
      end else if ((push_b[7:5] == u8d_pkg::LEAD2_TAG) ||
                   (push_b[7:4] == u8d_pkg::LEAD3_TAG) ||
                   (push_b[7:3] == u8d_pkg::LEAD4_TAG)) begin
        p_pend[0] = push_b;
        p_cnt     = 2'd1;
      end else begin
        p_emit = 1'b1;
        p_cp   = u8d_pkg::REPL_CP;
      end
    end else if (cnt_r == need_m1) begin
      p_emit = 1'b1;
      p_cnt  = 2'd0;
      if (need2) begin
        p_cp = {10'd0, lead[4:0], push_b[5:0]};
      end else if (need3) begin
        p_cp = {5'd0, lead[3:0], pend_r[1][5:0], push_b[5:0]};
      end else begin
        p_cp = {lead[2:0], pend_r[1][5:0], pend_r[2][5:0], push_b[5:0]};
      end
    end else begin
      case (cnt_r)
        2'd1:    p_pend[1] = push_b;
        default: p_pend[2] = push_b;
      endcase
      p_cnt = cnt_r + 2'd1;
    end
  end

  always_comb begin
    st_nxt        = st_r;
    pend_nxt      = pend_r;
    cnt_nxt       = cnt_r;
    q_nxt         = q_r;
    qn_nxt        = qn_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    cp_nxt        = cp_r;
    end_nxt       = end_r;
    last_nxt      = last_r;
    if (adv) begin
      if (st_r == ST_FLUSH) begin
        if (qn_r != 2'd0) begin
          // replay the oldest buffered byte as a fresh one
          pend_nxt      = p_pend;
          cnt_nxt       = p_cnt;
          q_nxt[0]      = q_r[1];
          qn_nxt        = qn_r - 2'd1;
          out_valid_nxt = p_emit;
          cp_nxt        = p_cp;
          end_nxt       = 1'b0;
          last_nxt      = 1'b0;
        end else if (cnt_r != 2'd0) begin
          q_nxt[0]      = pend_r[1];
          q_nxt[1]      = pend_r[2];
          qn_nxt        = cnt_r - 2'd1;
          cnt_nxt       = 2'd0;
          out_valid_nxt = 1'b1;
          cp_nxt        = u8d_pkg::REPL_CP;
          end_nxt       = 1'b0;
          last_nxt      = 1'b0;
        end else begin
          st_nxt        = ST_RUN;
          out_valid_nxt = 1'b1;
          cp_nxt        = '0;
          end_nxt       = 1'b1;
          last_nxt      = 1'b1;
        end
      end else if (in_fire) begin
        if (in_ch.in_byte == '0) begin
          if (cnt_r == 2'd0) begin
            out_valid_nxt = 1'b1;
            cp_nxt        = '0;
            end_nxt       = 1'b1;
            last_nxt      = 1'b1;
          end else begin
            q_nxt[0]      = pend_r[1];
            q_nxt[1]      = pend_r[2];
            qn_nxt        = cnt_r - 2'd1;
            cnt_nxt       = 2'd0;
            st_nxt        = ST_FLUSH;
            out_valid_nxt = 1'b1;
            cp_nxt        = u8d_pkg::REPL_CP;
            end_nxt       = 1'b0;
            last_nxt      = 1'b0;
          end
        end else begin
          pend_nxt      = p_pend;
          cnt_nxt       = p_cnt;
          out_valid_nxt = p_emit;
          cp_nxt        = p_cp;
          end_nxt       = 1'b0;
          last_nxt      = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_RUN;
      cnt_r       <= 2'd0;
      qn_r        <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      qn_r        <= qn_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    q_r    <= q_nxt;
    cp_r   <= cp_nxt;
    end_r  <= end_nxt;
    last_r <= last_nxt;
  end

  a_flush_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_FLUSH) |-> !in_ch.ready)
    else $error("input taken during flush");

  a_queue_only_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (qn_r != 2'd0) |-> (st_r == ST_FLUSH))
    else $error("replay queue loaded outside flush");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && end_r) |-> (last_r && (cp_r == '0)))
    else $error("end word without last");

  a_flush_closes: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r == ST_FLUSH) && adv && (qn_r == 2'd0) && (cnt_r == 2'd0)) |=>
      (out_valid_r && end_r && (st_r == ST_RUN)))
    else $error("flush did not close with end word");

endmodule
